/* rtl/sle_pkg.sv */
// Shared types, codes and defaults for the sequential list engine.
package sle_pkg;

  localparam int DEPTH_DEF      = 64;
  localparam int ELEM_WIDTH_DEF = 32;

  localparam int POS_W   = 7;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 7;

  typedef enum logic [2:0] {
    CMD_INSERT        = 3'd0,
    CMD_APPEND        = 3'd1,
    CMD_DELETE        = 3'd2,
    CMD_READ          = 3'd3,
    CMD_REVERSE       = 3'd4,
    CMD_SORT          = 3'd5,
    CMD_SORTED_INSERT = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    cmd_t                      command;
    logic [POS_W-1:0]          position;
    logic signed [VALUE_W-1:0] value;
  } in_t;

  typedef struct packed {
    status_t                   status;
    logic signed [VALUE_W-1:0] data;
    logic [COUNT_W-1:0]        count;
  } out_t;

  typedef struct packed {
    logic idle;
    logic done;
  } stat_t;

endpackage

/* rtl/sle_store.sv */
// Element store: single write port, single read port with registered read data.
module sle_store #(
  parameter int DEPTH = sle_pkg::DEPTH_DEF,
  parameter int W     = sle_pkg::ELEM_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);
  import sle_pkg::*;

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/sle_cmp.sv */
// Shared signed comparator used by the sort passes and the sorted-insert search.
module sle_cmp #(
  parameter int W = sle_pkg::ELEM_WIDTH_DEF
) (
  input  logic [W-1:0] x,
  input  logic [W-1:0] y,
  output logic         gt
);
  import sle_pkg::*;

  // Elements are two's complement of W bits.
  assign gt = $signed(x) > $signed(y);

endmodule

/* rtl/sle_ctrl.sv */
// Sequencer that walks the element store for every list command.
module sle_ctrl #(
  parameter int DEPTH      = sle_pkg::DEPTH_DEF,
  parameter int ELEM_WIDTH = sle_pkg::ELEM_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cmd_valid,
  input  sle_pkg::in_t             cmd,
  input  logic                     take,
  output sle_pkg::out_t            result,
  output sle_pkg::stat_t           stat,
  output logic                     mem_we,
  output logic [$clog2(DEPTH)-1:0] mem_waddr,
  output logic [ELEM_WIDTH-1:0]    mem_wdata,
  output logic [$clog2(DEPTH)-1:0] mem_raddr,
  input  logic [ELEM_WIDTH-1:0]    mem_rdata,
  output logic [ELEM_WIDTH-1:0]    cmp_x,
  output logic [ELEM_WIDTH-1:0]    cmp_y,
  input  logic                     cmp_gt
);
  import sle_pkg::*;

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;
  localparam int EW   = ELEM_WIDTH;

  typedef enum logic [17:0] {
    S_IDLE     = 18'h00001,
    S_UP       = 18'h00002,
    S_UP_WR    = 18'h00004,
    S_RD       = 18'h00008,
    S_RD_DATA  = 18'h00010,
    S_DN       = 18'h00020,
    S_DN_WR    = 18'h00040,
    S_RV_A     = 18'h00080,
    S_RV_B     = 18'h00100,
    S_RV_WA    = 18'h00200,
    S_RV_WB    = 18'h00400,
    S_SRT      = 18'h00800,
    S_SRT_LD   = 18'h01000,
    S_SRT_CMP  = 18'h02000,
    S_SRT_END  = 18'h04000,
    S_SRCH     = 18'h08000,
    S_SRCH_CMP = 18'h10000,
    S_FIN      = 18'h20000
  } state_t;

  state_t            state, state_next;
  logic [CW-1:0]     cnt, cnt_next;
  logic [CW-1:0]     i, i_next;
  logic [CW-1:0]     j, j_next;
  logic [CW-1:0]     lim, lim_next;
  cmd_t              cmd_r, cmd_r_next;
  logic [EW-1:0]     val, val_next;
  logic [EW-1:0]     a, a_next;
  status_t           status, status_next;
  logic [VALUE_W-1:0] data, data_next;

  logic [EW+VALUE_W-1:0] rd_ext;
  logic [EW+VALUE_W-1:0] in_ext;
  logic [EW-1:0]         in_val;
  logic [CMPW-1:0]       pos_x, cnt_x, cnt_p1;
  logic [CW-1:0]         pos_c, i_m1, j_p1, j_p2;
  logic                  ins_bad, del_bad, rd_bad, full;

  assign rd_ext = {{VALUE_W{mem_rdata[EW-1]}}, mem_rdata};
  assign in_ext = {{EW{cmd.value[VALUE_W-1]}}, cmd.value};
  assign in_val = in_ext[EW-1:0];

  assign pos_x  = CMPW'(cmd.position);
  assign cnt_x  = CMPW'(cnt);
  assign cnt_p1 = cnt_x + CMPW'(1);
  assign pos_c  = pos_x[CW-1:0];
  assign i_m1   = i - CW'(1);
  assign j_p1   = j + CW'(1);
  assign j_p2   = j + CW'(2);

  assign ins_bad = (pos_x == '0) || (pos_x > cnt_p1);
  assign del_bad = (pos_x == '0) || (pos_x > cnt_x);
  assign rd_bad  = (pos_x >= cnt_x);
  assign full    = (cnt == CW'(DEPTH));

  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    i_next      = i;
    j_next      = j;
    lim_next    = lim;
    cmd_r_next  = cmd_r;
    val_next    = val;
    a_next      = a;
    status_next = status;
    data_next   = data;
    mem_we      = 1'b0;
    mem_waddr   = i[AW-1:0];
    mem_wdata   = a;
    mem_raddr   = i[AW-1:0];
    cmp_x       = a;
    cmp_y       = mem_rdata;
    stat.idle   = 1'b0;
    stat.done   = 1'b0;

    case (state)
      S_IDLE: begin
        stat.idle = 1'b1;
        if (cmd_valid) begin
          cmd_r_next  = cmd.command;
          val_next    = in_val;
          status_next = ST_DONE;
          data_next   = '0;
          state_next  = S_FIN;
          case (cmd.command)
            CMD_INSERT: begin
              if (ins_bad) begin
                status_next = ST_RANGE;
              end else if (full) begin
                status_next = ST_FULL;
              end else begin
                i_next     = cnt;
                j_next     = pos_c - CW'(1);
                state_next = S_UP;
              end
            end
            CMD_APPEND: begin
              if (full) begin
                status_next = ST_FULL;
              end else begin
                i_next     = cnt;
                j_next     = cnt;
                state_next = S_UP;
              end
            end
            CMD_DELETE: begin
              if (del_bad) begin
                status_next = ST_RANGE;
              end else begin
                i_next     = pos_c;
                state_next = S_RD;
              end
            end
            CMD_READ: begin
              if (rd_bad) begin
                status_next = ST_RANGE;
              end else begin
                i_next     = pos_c + CW'(1);
                state_next = S_RD;
              end
            end
            CMD_REVERSE: begin
              if (cnt > CW'(1)) begin
                i_next     = '0;
                j_next     = cnt - CW'(1);
                state_next = S_RV_A;
              end
            end
            CMD_SORT, CMD_SORTED_INSERT: begin
              lim_next   = (cnt == '0) ? '0 : cnt - CW'(1);
              state_next = S_SRT;
            end
            default: begin
              state_next = S_FIN;
            end
          endcase
        end
      end

      // Open a gap by moving entries up one slot, top first.
      S_UP: begin
        if (i > j) begin
          mem_raddr  = i_m1[AW-1:0];
          state_next = S_UP_WR;
        end else begin
          mem_we     = 1'b1;
          mem_waddr  = j[AW-1:0];
          mem_wdata  = val;
          cnt_next   = cnt + CW'(1);
          state_next = S_FIN;
        end
      end
      S_UP_WR: begin
        mem_we     = 1'b1;
        mem_waddr  = i[AW-1:0];
        mem_wdata  = mem_rdata;
        i_next     = i_m1;
        state_next = S_UP;
      end

      S_RD: begin
        mem_raddr  = i_m1[AW-1:0];
        state_next = S_RD_DATA;
      end
      S_RD_DATA: begin
        data_next  = rd_ext[VALUE_W-1:0];
        state_next = (cmd_r == CMD_DELETE) ? S_DN : S_FIN;
      end

      // Close the gap by moving entries down one slot, bottom first.
      S_DN: begin
        if (i < cnt) begin
          mem_raddr  = i[AW-1:0];
          state_next = S_DN_WR;
        end else begin
          cnt_next   = cnt - CW'(1);
          state_next = S_FIN;
        end
      end
      S_DN_WR: begin
        mem_we     = 1'b1;
        mem_waddr  = i_m1[AW-1:0];
        mem_wdata  = mem_rdata;
        i_next     = i + CW'(1);
        state_next = S_DN;
      end

      S_RV_A: begin
        if (i < j) begin
          mem_raddr  = i[AW-1:0];
          state_next = S_RV_B;
        end else begin
          state_next = S_FIN;
        end
      end
      S_RV_B: begin
        a_next     = mem_rdata;
        mem_raddr  = j[AW-1:0];
        state_next = S_RV_WA;
      end
      S_RV_WA: begin
        mem_we     = 1'b1;
        mem_waddr  = i[AW-1:0];
        mem_wdata  = mem_rdata;
        state_next = S_RV_WB;
      end
      S_RV_WB: begin
        mem_we     = 1'b1;
        mem_waddr  = j[AW-1:0];
        mem_wdata  = a;
        i_next     = i + CW'(1);
        j_next     = j - CW'(1);
        state_next = S_RV_A;
      end

      // One bubble pass carries the larger element upwards in register a.
      S_SRT: begin
        if (lim != '0) begin
          mem_raddr  = '0;
          j_next     = '0;
          state_next = S_SRT_LD;
        end else if (cmd_r == CMD_SORTED_INSERT) begin
          if (full) begin
            status_next = ST_FULL;
            state_next  = S_FIN;
          end else begin
            i_next     = '0;
            state_next = S_SRCH;
          end
        end else begin
          state_next = S_FIN;
        end
      end
      S_SRT_LD: begin
        a_next     = mem_rdata;
        mem_raddr  = j_p1[AW-1:0];
        state_next = S_SRT_CMP;
      end
      S_SRT_CMP: begin
        mem_we    = 1'b1;
        mem_waddr = j[AW-1:0];
        mem_wdata = cmp_gt ? mem_rdata : a;
        a_next    = cmp_gt ? a : mem_rdata;
        if (j_p1 == lim) begin
          state_next = S_SRT_END;
        end else begin
          mem_raddr = j_p2[AW-1:0];
          j_next    = j_p1;
        end
      end
      S_SRT_END: begin
        mem_we     = 1'b1;
        mem_waddr  = lim[AW-1:0];
        mem_wdata  = a;
        lim_next   = lim - CW'(1);
        state_next = S_SRT;
      end

      // Find the first element not smaller than the new value.
      S_SRCH: begin
        if (i < cnt) begin
          mem_raddr  = i[AW-1:0];
          state_next = S_SRCH_CMP;
        end else begin
          j_next     = cnt;
          i_next     = cnt;
          state_next = S_UP;
        end
      end
      S_SRCH_CMP: begin
        cmp_x = val;
        if (!cmp_gt) begin
          j_next     = i;
          i_next     = cnt;
          state_next = S_UP;
        end else begin
          i_next     = i + CW'(1);
          state_next = S_SRCH;
        end
      end

      S_FIN: begin
        stat.done = 1'b1;
        if (take) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    i      <= i_next;
    j      <= j_next;
    lim    <= lim_next;
    cmd_r  <= cmd_r_next;
    val    <= val_next;
    a      <= a_next;
    status <= status_next;
    data   <= data_next;
  end

  always_comb begin
    result.status = status;
    result.data   = data;
    result.count  = cnt_x[COUNT_W-1:0];
  end

endmodule

/* rtl/sequential_list_engine.sv */
// Top level of the sequential list engine: command channel, sequencer, store, comparator, result register.
//
// The block keeps an ordered list of signed elements in a store (one write port, one
// registered read port) plus a count. Command beats arrive on cmd_valid / cmd_ready with a
// command code, a position and a value; each yields exactly one result beat on
// res_valid / res_ready carrying status, data and the new count.
//
// One command is in flight at a time: cmd_ready is high only while the sequencer is idle.
// Read fetches one entry and append writes one; insert and delete at 1-based position p
// shift the entries from p to the top of the list by one slot, reverse swaps pairs from
// the ends inward, sort runs bubble passes, and sorted insert sorts, searches and shifts.
// The sequencer is ready for the next command in the cycle after the result is loaded.
// The single read port and the comparator, used once a cycle, set the time each takes.
//
// Results land in an output register, so the sequencer can take the next command while
// the previous result is still waiting. If the receiver holds res_ready low and a second
// result is finished, the sequencer waits in its final state until the register frees.
//
// A synchronous reset empties the list (count zero) and clears the result valid flag; the
// store contents are left as they are, since no command can reach an entry above the count.
module sequential_list_engine #(
  parameter int DEPTH      = sle_pkg::DEPTH_DEF,
  parameter int ELEM_WIDTH = sle_pkg::ELEM_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  sle_pkg::in_t   cmd,
  output logic           res_valid,
  input  logic           res_ready,
  output sle_pkg::out_t  res
);
  import sle_pkg::*;

  localparam int AW = $clog2(DEPTH);

  out_t                 result;
  stat_t                stat;
  logic                 take;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [AW-1:0]        mem_raddr;
  logic [ELEM_WIDTH-1:0] mem_wdata;
  logic [ELEM_WIDTH-1:0] mem_rdata;
  logic [ELEM_WIDTH-1:0] cmp_x;
  logic [ELEM_WIDTH-1:0] cmp_y;
  logic                 cmp_gt;

  // The sequencer only accepts a command while idle.
  assign cmd_ready = stat.idle;

  // The result register can be loaded when empty or when its beat is leaving.
  assign take = !res_valid || res_ready;

  sle_ctrl #(
    .DEPTH      (DEPTH),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .take      (take),
    .result    (result),
    .stat      (stat),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .cmp_x     (cmp_x),
    .cmp_y     (cmp_y),
    .cmp_gt    (cmp_gt)
  );

  sle_store #(
    .DEPTH (DEPTH),
    .W     (ELEM_WIDTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // The one comparator is shared between the bubble passes and the insert search.
  sle_cmp #(
    .W (ELEM_WIDTH)
  ) u_cmp (
    .x  (cmp_x),
    .y  (cmp_y),
    .gt (cmp_gt)
  );

  // Result register: valid is control state, the payload needs no reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (stat.done && take) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.done && take) begin
      res <= result;
    end
  end

endmodule

/* rtl/sle_check.sv */
// Port-level checker for the sequential list engine, bound to the top level.
module sle_check (
  input logic          clk,
  input logic          rst,
  input logic          cmd_valid,
  input logic          cmd_ready,
  input logic          res_valid,
  input logic          res_ready,
  input sle_pkg::out_t res
);
  import sle_pkg::*;

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // A stalled result beat holds.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result beat changed while stalled");

  // One command at a time: the block is busy in the cycle after an accept.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("command accepted while previous one in progress");

  // A rejected command never returns data.
  a_reject_no_data: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.status != ST_DONE) |-> (res.data == '0))
    else $error("rejected command returned data");

  // Status is always one of the defined codes.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.status == ST_DONE) || (res.status == ST_RANGE) ||
                  (res.status == ST_FULL))
    else $error("undefined status code");

endmodule

bind sequential_list_engine sle_check u_check (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_ready (cmd_ready),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .res       (res)
);

/* test/tb_sequential_list_engine.sv */
`timescale 1ns / 1ps
// Testbench for the sequential list engine: directed table, then predictor-checked random beats.
module tb_sequential_list_engine;
  import sle_pkg::*;

  localparam int LIST_DEPTH   = DEPTH_DEF;
  localparam int NUM_ROWS     = 25;
  localparam int NUM_RANDOM   = 400;
  localparam int HOLD_CYCLES  = 3000;
  localparam int DRAIN_CYCLES = 3000;
  localparam int REPORT_LIMIT = 10;

  // Command 7 has no name in the package; the block must treat it as a no-op.
  localparam cmd_t CMD_UNUSED = cmd_t'(3'd7);

  localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

  // Share of random commands that grow the list, one entry per block of 50 beats. The
  // middle blocks push the list to its full depth and hold it there for a while; the last
  // ones drain it again.
  localparam int GROW_PCT [8] = '{55, 40, 85, 85, 50, 45, 10, 10};

  // One row of the directed table. Where typed is set, st, dat and cnt are the result
  // that the row must give; otherwise the result comes from the predictor.
  typedef struct packed {
    cmd_t                      op;
    logic [POS_W-1:0]          pos;
    logic signed [VALUE_W-1:0] val;
    logic                      typed;
    status_t                   st;
    logic signed [VALUE_W-1:0] dat;
    logic [COUNT_W-1:0]        cnt;
  } row_t;

  logic  clk;
  logic  rst;
  logic  cmd_valid;
  logic  cmd_ready;
  in_t   cmd;
  logic  res_valid;
  logic  res_ready;
  out_t  res;

  // The predictor's own copy of the list.
  logic signed [VALUE_W-1:0] list_mem [LIST_DEPTH];
  int                        list_len = 0;

  out_t pending_res [$];
  row_t beat_tags [$];

  int   errors       = 0;
  int   results_seen = 0;
  logic calm         = 1'b0;
  logic held         = 1'b0;

  // Directed part. It starts on the empty list, walks through every command and the
  // position checks at both ends, including positions with the top bit set, the unused
  // command code, and reverse and sort on empty and single-element lists.
  row_t plan [NUM_ROWS] = '{
    '{CMD_READ,          7'd0,  32'sd0,  1'b1, ST_RANGE, 32'sd0,  7'd0},
    '{CMD_DELETE,        7'd1,  32'sd0,  1'b1, ST_RANGE, 32'sd0,  7'd0},
    '{CMD_INSERT,        7'd0,  32'sd5,  1'b1, ST_RANGE, 32'sd0,  7'd0},
    '{CMD_INSERT,        7'd2,  32'sd5,  1'b1, ST_RANGE, 32'sd0,  7'd0},
    '{CMD_REVERSE,       7'd0,  32'sd0,  1'b1, ST_DONE,  32'sd0,  7'd0},
    '{CMD_SORT,          7'd0,  32'sd0,  1'b1, ST_DONE,  32'sd0,  7'd0},
    '{CMD_INSERT,        7'd1,  VAL_MAX, 1'b1, ST_DONE,  32'sd0,  7'd1},
    '{CMD_APPEND,        7'd0,  VAL_MIN, 1'b1, ST_DONE,  32'sd0,  7'd2},
    '{CMD_READ,          7'd1,  32'sd0,  1'b1, ST_DONE,  VAL_MIN, 7'd2},
    '{CMD_READ,          7'd0,  32'sd0,  1'b1, ST_DONE,  VAL_MAX, 7'd2},
    '{CMD_SORT,          7'd0,  32'sd0,  1'b0, ST_DONE,  32'sd0,  7'd0},
    '{CMD_INSERT,        7'd2,  32'sd0,  1'b0, ST_DONE,  32'sd0,  7'd0},
    '{CMD_SORTED_INSERT, 7'd0,  -32'sd1, 1'b0, ST_DONE,  32'sd0,  7'd0},
    '{CMD_REVERSE,       7'd0,  32'sd0,  1'b0, ST_DONE,  32'sd0,  7'd0},
    '{CMD_DELETE,        7'd64, 32'sd0,  1'b1, ST_RANGE, 32'sd0,  7'd4},
    '{CMD_INSERT,        7'd65, 32'sd9,  1'b1, ST_RANGE, 32'sd0,  7'd4},
    '{CMD_READ,          7'd64, 32'sd0,  1'b1, ST_RANGE, 32'sd0,  7'd4},
    '{CMD_READ,          7'd4,  32'sd0,  1'b1, ST_RANGE, 32'sd0,  7'd4},
    '{CMD_UNUSED,        7'd0,  -32'sd1, 1'b1, ST_DONE,  32'sd0,  7'd4},
    '{CMD_DELETE,        7'd1,  32'sd0,  1'b0, ST_DONE,  32'sd0,  7'd0},
    '{CMD_DELETE,        7'd3,  32'sd0,  1'b0, ST_DONE,  32'sd0,  7'd0},
    '{CMD_DELETE,        7'd1,  32'sd0,  1'b0, ST_DONE,  32'sd0,  7'd0},
    '{CMD_REVERSE,       7'd0,  32'sd0,  1'b1, ST_DONE,  32'sd0,  7'd1},
    '{CMD_SORT,          7'd0,  32'sd0,  1'b1, ST_DONE,  32'sd0,  7'd1},
    '{CMD_SORTED_INSERT, 7'd0,  VAL_MIN, 1'b0, ST_DONE,  32'sd0,  7'd0}
  };

  sequential_list_engine DUT (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Predictor
  // ---------
  // Opens a gap at zero-based slot and drops the value into it.
  function automatic void place_elem(input int slot, input logic signed [VALUE_W-1:0] v);
    for (int i = list_len; i > slot; i--)
      list_mem[i] = list_mem[i - 1];
    list_mem[slot] = v;
    list_len++;
  endfunction

  // Ascending bubble sort; elements compare as signed numbers.
  function automatic void sort_list();
    logic signed [VALUE_W-1:0] t;
    for (int pass = 1; pass < list_len; pass++)
      for (int j = 0; j + pass < list_len; j++)
        if (list_mem[j] > list_mem[j + 1]) begin
          t = list_mem[j];
          list_mem[j] = list_mem[j + 1];
          list_mem[j + 1] = t;
        end
  endfunction

  // Applies one command beat to the predicted list and returns the result it must give.
  function automatic out_t list_apply(input in_t beat);
    out_t                      r;
    int                        p;
    int                        lo;
    int                        hi;
    int                        slot;
    logic signed [VALUE_W-1:0] t;
    r.status = ST_DONE;
    r.data   = '0;
    p        = int'(beat.position);
    case (beat.command)
      CMD_INSERT: begin
        // The position is checked before the list is found to be full.
        if (p < 1 || p > list_len + 1)
          r.status = ST_RANGE;
        else if (list_len >= LIST_DEPTH)
          r.status = ST_FULL;
        else
          place_elem(p - 1, beat.value);
      end
      CMD_APPEND: begin
        if (list_len >= LIST_DEPTH)
          r.status = ST_FULL;
        else
          place_elem(list_len, beat.value);
      end
      CMD_DELETE: begin
        if (p < 1 || p > list_len) begin
          r.status = ST_RANGE;
        end else begin
          r.data = list_mem[p - 1];
          for (int i = p; i < list_len; i++)
            list_mem[i - 1] = list_mem[i];
          list_len--;
        end
      end
      CMD_READ: begin
        if (p >= list_len)
          r.status = ST_RANGE;
        else
          r.data = list_mem[p];
      end
      CMD_REVERSE: begin
        lo = 0;
        hi = list_len - 1;
        while (lo < hi) begin
          t = list_mem[lo];
          list_mem[lo] = list_mem[hi];
          list_mem[hi] = t;
          lo++;
          hi--;
        end
      end
      CMD_SORT: sort_list();
      CMD_SORTED_INSERT: begin
        // A full list is still sorted; only the placement is refused.
        sort_list();
        if (list_len >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          slot = 0;
          while (slot < list_len && beat.value > list_mem[slot])
            slot++;
          place_elem(slot, beat.value);
        end
      end
      default: ;
    endcase
    r.count = list_len[COUNT_W-1:0];
    return r;
  endfunction

  // Random stimulus
  // ---------------
  // Builds a random command beat. Most positions land inside the list as it stands, so
  // that inserts and deletes really move entries; the rest are drawn from 0 to 65,
  // the out-of-range cases among them.
  function automatic in_t random_command(input int grow_pct);
    in_t b;
    int  roll;
    roll       = $urandom_range(0, 99);
    b.position = POS_W'($urandom_range(0, 65));
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0:       b.value = VAL_MIN;
          1:       b.value = VAL_MAX;
          2:       b.value = '0;
          default: b.value = '1;
        endcase
      end
      1, 2:    b.value = $urandom_range(0, 8) - 4;   // small values give duplicates
      default: b.value = $urandom;
    endcase
    if (roll < grow_pct) begin
      case ($urandom_range(0, 7))
        0:       b.command = CMD_SORTED_INSERT;
        1, 2, 3: b.command = CMD_APPEND;
        default: b.command = CMD_INSERT;
      endcase
      if (b.command == CMD_INSERT && $urandom_range(0, 9) < 8)
        b.position = POS_W'($urandom_range(1, list_len + 1));
    end else if (roll < 90) begin
      b.command = ($urandom_range(0, 3) == 0) ? CMD_READ : CMD_DELETE;
      if (list_len > 0 && $urandom_range(0, 9) < 8)
        b.position = (b.command == CMD_READ) ? POS_W'($urandom_range(0, list_len - 1))
                                             : POS_W'($urandom_range(1, list_len));
    end else if (roll < 95) begin
      b.command = CMD_REVERSE;
    end else if (roll < 99) begin
      b.command = CMD_SORT;
    end else begin
      b.command = CMD_UNUSED;
    end
    return b;
  endfunction

  task automatic log_failure(input string msg);
    errors++;
    if (errors <= REPORT_LIMIT)
      $display("ERROR at %0t ns: %s", $time, msg);
  endtask

  // Command side. Called at a falling edge; returns at the falling edge after the beat has
  // been taken. Between beats it may leave valid low for a random gap, except in the calm
  // stretch. When no gap is taken valid simply stays high for the next beat.
  task automatic send_beat(input in_t beat, input row_t tag);
    if (!calm) begin
      while ($urandom_range(0, 99) < 31) begin
        cmd_valid <= 1'b0;
        @(negedge clk);
      end
    end
    beat_tags.push_back(tag);
    cmd       <= beat;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (!cmd_ready);
    @(negedge clk);
  endtask

  // Both channels are watched at the rising edge. A command beat updates the predictor
  // and queues the result it must give; a result beat is checked against the oldest one.
  always @(posedge clk) begin
    row_t tag;
    out_t want;
    out_t predicted;
    if (!rst && cmd_valid && cmd_ready) begin
      tag       = beat_tags.pop_front();
      predicted = list_apply(cmd);
      if (tag.typed) begin
        want.status = tag.st;
        want.data   = tag.dat;
        want.count  = tag.cnt;
      end else begin
        want = predicted;
      end
      pending_res.push_back(want);
    end
    if (!rst && res_valid && res_ready) begin
      results_seen++;
      if (pending_res.size() == 0) begin
        log_failure($sformatf("result beat with nothing outstanding: status %0d data %0d count %0d",
                              res.status, res.data, res.count));
      end else begin
        want = pending_res.pop_front();
        if (res.status !== want.status || res.data !== want.data || res.count !== want.count)
          log_failure($sformatf({"result %0d: expected status %0d data %0d count %0d, ",
                                 "got status %0d data %0d count %0d"},
                                results_seen, want.status, want.data, want.count,
                                res.status, res.data, res.count));
      end
    end
  end

  // Result side. Ready drops at random, except in the calm stretch. Once, some way into
  // the run, the receiver holds off for a long while so that the output register and the
  // sequencer both fill up and the block has to refuse further commands.
  initial begin
    res_ready = 1'b0;
    @(negedge clk);
    forever begin
      if (!held && results_seen >= 150) begin
        held = 1'b1;
        res_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        res_ready <= calm || ($urandom_range(0, 99) >= 31);
        @(negedge clk);
      end
    end
  end

  // Main sequence: reset, the directed table, the random commands, then the drain.
  initial begin
    in_t  beat;
    row_t tag;
    cmd_valid = 1'b0;
    cmd       = '0;
    rst       = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int k = 0; k < NUM_ROWS; k++) begin
      tag            = plan[k];
      beat.command   = tag.op;
      beat.position  = tag.pos;
      beat.value     = tag.val;
      send_beat(beat, tag);
    end

    for (int k = 0; k < NUM_RANDOM; k++) begin
      calm = (k >= 200 && k < 260);
      beat = random_command(GROW_PCT[k / 50]);
      tag  = '0;
      send_beat(beat, tag);
    end
    calm = 1'b0;
    cmd_valid <= 1'b0;

    while (pending_res.size() != 0 || beat_tags.size() != 0)
      @(posedge clk);
    // Every command gives a result, so nothing should follow; watch for strays a while.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // Backstop against a hung handshake: far beyond a run of full-list sorts with every stall.
  initial begin
    #60_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
